@@ hw/rtl/vmc_pkg.sv @@
// ----------------------------------------------------------------------------
// vmc_pkg: shared types and constants for the velocity magnitude clamp
// Field widths, pipeline depths, register indexes and per-cell state types.
// ----------------------------------------------------------------------------
`default_nettype none

package vmc_pkg;

   localparam int COMP_W     = 32;              // Q16.16 component width
   localparam int CAP_W      = 31;              // speed cap register width
   localparam int SQ_W       = 2 * COMP_W;      // Q32.32 sum of squares
   localparam int SQRT_STEPS = SQ_W / 2;        // one root bit per cell
   localparam int REM_W      = COMP_W + 2;      // square root remainder
   localparam int DIV_STEPS  = CAP_W;           // one quotient bit per cell
   localparam int PROD_W     = 2 * CAP_W;       // |c| * cap stays below 2^62
   localparam int LANE_LAT   = 2 + SQRT_STEPS + 1 + DIV_STEPS;
   localparam int PIPE_LAT   = LANE_LAT + 1;    // plus the output register

   localparam int REQ_W = 6 * COMP_W;
   localparam int RSP_W = ((6 * COMP_W + 2 + 7) / 8) * 8;

   typedef enum logic {
      REG_LIN_CAP = 1'b0,
      REG_ANG_CAP = 1'b1
   } reg_index_type;

   typedef logic [2:0][COMP_W-1:0] comp_vec_type;

   typedef struct packed {
      logic [SQ_W-1:0]   rad;
      logic [REM_W-1:0]  rem;
      logic [COMP_W-1:0] root;
   } sqrt_st_type;

   typedef struct packed {
      logic [COMP_W-1:0]    rem;
      logic [DIV_STEPS-1:0] low;
      logic [DIV_STEPS-1:0] quo;
      logic [COMP_W-1:0]    dvs;
   } div_st_type;

endpackage

`default_nettype wire

@@ hw/rtl/velocity_magnitude_clamp_top.sv @@
// An accepted request passes through both lane pipelines and the output register to its response.
// Throughput: one transaction per cycle while rsp_tready stays high; the
// 32-cell square root row and the 31-cell division rows each take one step
// per cycle and all advance together.
// Reset: synchronous, active high; clears the valid chain and sets both
// speed caps to 0x7FFFFFFF.
// ----------------------------------------------------------------------------
// velocity_magnitude_clamp_top: speed limiter for linear and angular velocity
// Two lanes, one per vector, each built from rows of pipelined cells.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_magnitude_clamp_top
   import vmc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // Request stream. tdata: lin_x, lin_y, lin_z, ang_x, ang_y, ang_z.
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // Response stream. tdata: out_lin_x, out_lin_y, out_lin_z, out_ang_x,
   // out_ang_y, out_ang_z, clamp_count, then zero fill.
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // Register write port.
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [CAP_W-1:0] csr_wdata
);

   logic [CAP_W-1:0] lin_cap_ff, ang_cap_ff;
   logic [PIPE_LAT-1:0] valid_ff;
   logic             en;
   comp_vec_type     lin_in, ang_in, lin_out, ang_out;
   logic             lin_clamp, ang_clamp;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // The whole pipeline advances together whenever the output register is
   // empty or being drained, so a new transaction is taken every such cycle.
   assign en         = !valid_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[PIPE_LAT-1];
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_cap_ff <= '1;
         ang_cap_ff <= '1;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_LIN_CAP: lin_cap_ff <= csr_wdata;
            REG_ANG_CAP: ang_cap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lin_in[i] = req_tdata[i*COMP_W +: COMP_W];
         ang_in[i] = req_tdata[(i+3)*COMP_W +: COMP_W];
      end
   end

   vmc_lane u_lin (
      .clock   (clock),
      .en      (en),
      .cap     (lin_cap_ff),
      .vec_in  (lin_in),
      .vec_out (lin_out),
      .clamp   (lin_clamp)
   );

   vmc_lane u_ang (
      .clock   (clock),
      .en      (en),
      .cap     (ang_cap_ff),
      .vec_in  (ang_in),
      .vec_out (ang_out),
      .clamp   (ang_clamp)
   );

   // Pack the response; the clamp count sits just above the six components.
   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < 3; i++) begin
         rsp_data_in[i*COMP_W +: COMP_W]     = lin_out[i];
         rsp_data_in[(i+3)*COMP_W +: COMP_W] = ang_out[i];
      end
      rsp_data_in[6*COMP_W +: 2] = {1'b0, lin_clamp} + {1'b0, ang_clamp};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/vmc_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// vmc_sqrt_cell: one step of the digit-by-digit integer square root
// Brings down two radicand bits and decides one root bit, then registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_sqrt_cell
   import vmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire sqrt_st_type st_in,
   output sqrt_st_type      st_out
);

   sqrt_st_type st_ff, st_next_in;
   logic [REM_W+1:0] part;
   logic [REM_W+1:0] trial;
   logic             ge;

   always_comb begin
      part  = {st_in.rem, st_in.rad[SQ_W-1 -: 2]};
      trial = {2'b00, st_in.root, 2'b01};
      ge    = (part >= trial);
      st_next_in.rad  = {st_in.rad[SQ_W-3:0], 2'b00};
      st_next_in.rem  = ge ? REM_W'(part - trial) : REM_W'(part);
      st_next_in.root = {st_in.root[COMP_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_next_in;
      end
   end

   assign st_out = st_ff;

endmodule

`default_nettype wire

@@ hw/rtl/vmc_div_cell.sv @@
// ----------------------------------------------------------------------------
// vmc_div_cell: one step of restoring division
// Shifts in one dividend bit, subtracts the divisor when it fits, registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_div_cell
   import vmc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       en,
   input  wire div_st_type st_in,
   output div_st_type      st_out
);

   div_st_type st_ff, st_next_in;
   logic [COMP_W:0] part;
   logic            ge;

   always_comb begin
      part = {st_in.rem, st_in.low[DIV_STEPS-1]};
      ge   = (part >= {1'b0, st_in.dvs});
      st_next_in.rem = ge ? COMP_W'(part - {1'b0, st_in.dvs}) : COMP_W'(part);
      st_next_in.low = {st_in.low[DIV_STEPS-2:0], 1'b0};
      st_next_in.quo = {st_in.quo[DIV_STEPS-2:0], ge};
      st_next_in.dvs = st_in.dvs;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_next_in;
      end
   end

   assign st_out = st_ff;

endmodule

`default_nettype wire

@@ hw/rtl/vmc_lane.sv @@
// ----------------------------------------------------------------------------
// vmc_lane: clamp pipeline for one 3-vector
// Squares, sum, a row of square root cells, compare and scale, then a row
// of division cells per component.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_lane
   import vmc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [CAP_W-1:0] cap,
   input  wire comp_vec_type     vec_in,
   output comp_vec_type          vec_out,
   output logic                  clamp
);

   comp_vec_type          comp1_ff, comp2_ff, comp3_ff;
   logic [2:0][COMP_W-1:0] mag_in, mag1_ff, mag2_ff;
   logic [2:0][SQ_W-1:0]   sq_in, sq1_ff;
   logic [SQ_W-1:0]        sum2_ff;

   comp_vec_type           comp_d_ff [SQRT_STEPS];
   logic [2:0][COMP_W-1:0] mag_d_ff  [SQRT_STEPS];
   sqrt_st_type            sq_st     [SQRT_STEPS+1];

   logic [2:0][PROD_W-1:0] prod_in, prod3_ff;
   logic [COMP_W-1:0]      len3_ff;
   logic                   clamp3_ff;

   comp_vec_type           cd_ff [DIV_STEPS];
   logic                   cl_ff [DIV_STEPS];
   div_st_type             dv_st [3][DIV_STEPS+1];

   // Magnitudes and squares. The most negative word has magnitude 2^31.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = vec_in[i][COMP_W-1] ? COMP_W'(-vec_in[i]) : vec_in[i];
         sq_in[i]  = {{COMP_W{1'b0}}, mag_in[i]} * {{COMP_W{1'b0}}, mag_in[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp1_ff <= vec_in;
         mag1_ff  <= mag_in;
         sq1_ff   <= sq_in;
         comp2_ff <= comp1_ff;
         mag2_ff  <= mag1_ff;
         sum2_ff  <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
      end
   end

   // Square root row.
   assign sq_st[0] = '{rad: sum2_ff, rem: '0, root: '0};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      vmc_sqrt_cell u_cell (
         .clock  (clock),
         .en     (en),
         .st_in  (sq_st[k]),
         .st_out (sq_st[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp_d_ff[0] <= comp2_ff;
         mag_d_ff[0]  <= mag2_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            comp_d_ff[k] <= comp_d_ff[k-1];
            mag_d_ff[k]  <= mag_d_ff[k-1];
         end
      end
   end

   // Compare against the cap and form |c| * cap.
   logic [2*COMP_W-2:0] prod_full [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_full[i] = {{(CAP_W){1'b0}}, mag_d_ff[SQRT_STEPS-1][i]}
                        * {{COMP_W{1'b0}}, cap};
         prod_in[i]   = prod_full[i][PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         comp3_ff  <= comp_d_ff[SQRT_STEPS-1];
         prod3_ff  <= prod_in;
         len3_ff   <= sq_st[SQRT_STEPS].root;
         clamp3_ff <= (sq_st[SQRT_STEPS].root > {1'b0, cap});
      end
   end

   // Division rows, one per component; quotient fits the cap width.
   for (genvar i = 0; i < 3; i++) begin : g_comp
      assign dv_st[i][0] = '{rem: {1'b0, prod3_ff[i][PROD_W-1 -: CAP_W]},
                             low: prod3_ff[i][DIV_STEPS-1:0],
                             quo: '0,
                             dvs: len3_ff};
      for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
         vmc_div_cell u_cell (
            .clock  (clock),
            .en     (en),
            .st_in  (dv_st[i][k]),
            .st_out (dv_st[i][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cd_ff[0] <= comp3_ff;
         cl_ff[0] <= clamp3_ff;
         for (int k = 1; k < DIV_STEPS; k++) begin
            cd_ff[k] <= cd_ff[k-1];
            cl_ff[k] <= cl_ff[k-1];
         end
      end
   end

   // Reapply the sign; unclamped vectors pass through untouched.
   logic [COMP_W-1:0] qx [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qx[i] = {1'b0, dv_st[i][DIV_STEPS].quo};
         if (cl_ff[DIV_STEPS-1]) begin
            vec_out[i] = cd_ff[DIV_STEPS-1][i][COMP_W-1] ? COMP_W'(-qx[i]) : qx[i];
         end else begin
            vec_out[i] = cd_ff[DIV_STEPS-1][i];
         end
      end
   end

   assign clamp = cl_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/vmc_checker.sv @@
// ----------------------------------------------------------------------------
// vmc_checker: port-level assertions for the velocity magnitude clamp
// Watches the stream handshakes and the response count field.
// ----------------------------------------------------------------------------
`default_nettype none

module vmc_checker
   import vmc_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // A stalled response must stay presented.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // No request transaction is taken while the response side is stalled.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted during output stall");

   // At most two vectors can be clamped.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6*COMP_W +: 2] != 2'd3)
      else $error("clamp count out of range");

   // Reset empties the pipeline.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind velocity_magnitude_clamp_top vmc_checker u_vmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
